// ===== design/response_frame_checker_assert.svh =====
// assertion macros used by the response frame checker
`ifndef RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define RESPONSE_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RFC_ASSERT_HOLD(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("response_frame_checker: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define RFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("response_frame_checker: next-cycle check failed");

`endif

// ===== design/rfc_pkg.sv =====
package rfc_pkg;

   // receive window length in bytes
   localparam int WINDOW = 16;

   // frame constants
   localparam logic [7:0] HDR_BYTE = 8'h5a;
   localparam logic [7:0] SUM_OK   = 8'hff;
   localparam int DATA_MAX = 12;

   // widths derived from the window and payload size
   localparam int POS_W = $clog2(WINDOW + 1);
   localparam int OFF_W = $clog2(WINDOW);
   localparam int CHK_W = $clog2(WINDOW + 256) + 1;
   localparam int IDX_W = $clog2(DATA_MAX);
   localparam int CNT_W = $clog2(DATA_MAX + 1);

   typedef enum logic [2:0] {
      VERDICT_OK          = 3'd0,
      VERDICT_NO_HEADER   = 3'd1,
      VERDICT_BAD_SUM     = 3'd2,
      VERDICT_SHORT       = 3'd3,
      VERDICT_PAST_WINDOW = 3'd4
   } verdict_type;

endpackage

// ===== design/response_frame_checker.sv =====
// Response frame checker: takes one received byte per word on the req_ side, WINDOW bytes
// per window (window_start marks position zero), finds the first 0x5a header at positions
// 0 to WINDOW-5 and checks the frame header, length, status, data, checksum whose bytes sum
// to 0xff. On the window's last byte one verdict word goes out on the rsp_ side, followed
// on ok by one word per data byte (at most 12), one word per cycle while rsp_ready is
// high. Input bytes are taken one per cycle; the single result sequencer holds the last
// byte of a window only while the previous window's words are still being drained, so a
// window of WINDOW >= 13 bytes sustains one byte per cycle when the result side does not
// stall. Bytes after the window end are accepted and dropped until the next window_start.
`include "response_frame_checker_assert.svh"

module response_frame_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_window_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [2:0] rsp_verdict,
   output logic [7:0] rsp_frame_status,
   output logic [3:0] rsp_data_count,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_data_index,
   output logic       rsp_last
);

   localparam int POS_W = rfc_pkg::POS_W;
   localparam int OFF_W = rfc_pkg::OFF_W;
   localparam int CHK_W = rfc_pkg::CHK_W;
   localparam int IDX_W = rfc_pkg::IDX_W;
   localparam int CNT_W = rfc_pkg::CNT_W;

   // window tracking state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hdr_ff, hdr_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       status_ff, status_in;
   logic [7:0]       pay_ff [rfc_pkg::DATA_MAX];
   logic [7:0]       pay_in [rfc_pkg::DATA_MAX];

   // result sequencer state
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     emit_idx_ff, emit_idx_in;
   rfc_pkg::verdict_type verdict_ff, verdict_in;
   logic [7:0]           ostat_ff, ostat_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [7:0]           snap_ff [rfc_pkg::DATA_MAX];

   logic             req_fire, rsp_fire, last_word, load;
   logic             hdr_cur;
   logic [POS_W-1:0] pos_cur, rel;
   logic [OFF_W-1:0] off_cur;
   logic [7:0]       len_cur, len_eff, sum_cur, status_cur, len_m4;
   logic [CHK_W-1:0] end_sum, pay_rel;
   logic             in_window, pay_we;
   logic [IDX_W-1:0] pay_idx, rd_idx;
   logic [CNT_W-1:0] cnt_calc, emit_step;
   logic             verdict_err, mid_fire;

   // handshakes
   assign last_word = (emit_idx_ff == cnt_ff);
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = (pos_cur != POS_W'(rfc_pkg::WINDOW - 1)) || !rsp_valid_ff ||
                      (rsp_ready && last_word);
   assign req_fire  = req_valid && req_ready;

   // state as seen after an optional window restart
   assign pos_cur    = req_window_start ? '0 : pos_ff;
   assign hdr_cur    = req_window_start ? 1'b0 : hdr_ff;
   assign off_cur    = req_window_start ? '0 : off_ff;
   assign len_cur    = req_window_start ? '0 : len_ff;
   assign sum_cur    = req_window_start ? '0 : sum_ff;
   assign status_cur = req_window_start ? '0 : status_ff;

   assign in_window = (CHK_W'(pos_cur) < CHK_W'(rfc_pkg::WINDOW));
   assign rel       = pos_cur - POS_W'(off_cur);
   assign len_eff   = (rel == POS_W'(1)) ? req_rx_byte : len_cur;
   assign pay_rel   = CHK_W'(rel) - CHK_W'(3);
   assign pay_we    = hdr_cur && (CHK_W'(rel) >= CHK_W'(3)) &&
                      (pay_rel < CHK_W'(rfc_pkg::DATA_MAX));
   assign pay_idx   = pay_rel[IDX_W-1:0];
   assign load      = req_fire && (pos_cur == POS_W'(rfc_pkg::WINDOW - 1));

   // per-byte frame tracking
   always_comb begin
      hdr_in    = hdr_cur;
      off_in    = off_cur;
      len_in    = len_cur;
      sum_in    = sum_cur;
      status_in = status_cur;
      pos_in    = pos_cur;
      for (int i = 0; i < rfc_pkg::DATA_MAX; i++) begin
         pay_in[i] = pay_ff[i];
      end
      if (in_window) begin
         pos_in = pos_cur + POS_W'(1);
         if (!hdr_cur) begin
            if ((CHK_W'(pos_cur) + CHK_W'(4) < CHK_W'(rfc_pkg::WINDOW)) &&
                (req_rx_byte == rfc_pkg::HDR_BYTE)) begin
               hdr_in = 1'b1;
               off_in = pos_cur[OFF_W-1:0];
               sum_in = req_rx_byte;
            end
         end else begin
            len_in = len_eff;
            if (CHK_W'(rel) < CHK_W'(len_eff)) begin
               sum_in = sum_cur + req_rx_byte;
            end
            if (rel == POS_W'(2)) begin
               status_in = req_rx_byte;
            end
            if (pay_we) begin
               pay_in[pay_idx] = req_rx_byte;
            end
         end
      end
   end

   // verdict at the window's last byte
   assign end_sum  = CHK_W'(off_cur) + CHK_W'(len_cur);
   assign len_m4   = len_cur - 8'd4;
   assign cnt_calc = (len_m4 > 8'(rfc_pkg::DATA_MAX)) ? CNT_W'(rfc_pkg::DATA_MAX)
                                                      : len_m4[CNT_W-1:0];

   always_comb begin
      verdict_in = rfc_pkg::VERDICT_OK;
      if (!hdr_cur) begin
         verdict_in = rfc_pkg::VERDICT_NO_HEADER;
      end else if (len_cur < 8'd4) begin
         verdict_in = rfc_pkg::VERDICT_SHORT;
      end else if (end_sum > CHK_W'(rfc_pkg::WINDOW)) begin
         verdict_in = rfc_pkg::VERDICT_PAST_WINDOW;
      end else if (sum_in != rfc_pkg::SUM_OK) begin
         verdict_in = rfc_pkg::VERDICT_BAD_SUM;
      end
      ostat_in = (verdict_in == rfc_pkg::VERDICT_OK) ? status_cur : 8'd0;
      cnt_in   = (verdict_in == rfc_pkg::VERDICT_OK) ? cnt_calc : '0;
   end

   // result sequencer next state
   assign emit_step = emit_idx_ff + CNT_W'(1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      emit_idx_in  = emit_idx_ff;
      if (rsp_fire) begin
         if (last_word) begin
            rsp_valid_in = 1'b0;
         end else begin
            emit_idx_in = emit_step;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         emit_idx_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_ff       <= 1'b0;
         off_ff       <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         if (req_fire) begin
            pos_ff    <= pos_in;
            hdr_ff    <= hdr_in;
            off_ff    <= off_in;
            len_ff    <= len_in;
            sum_ff    <= sum_in;
            status_ff <= status_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   // payload store and result snapshot
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < rfc_pkg::DATA_MAX; i++) begin
            pay_ff[i] <= pay_in[i];
         end
      end
      if (load) begin
         verdict_ff <= verdict_in;
         ostat_ff   <= ostat_in;
         cnt_ff     <= cnt_in;
         for (int i = 0; i < rfc_pkg::DATA_MAX; i++) begin
            snap_ff[i] <= pay_in[i];
         end
      end
   end

   // result word fields
   assign rd_idx           = IDX_W'(emit_idx_ff - CNT_W'(1));
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = (emit_idx_ff != '0);
   assign rsp_verdict      = verdict_ff;
   assign rsp_frame_status = ostat_ff;
   assign rsp_data_count   = 4'(cnt_ff);
   assign rsp_data_byte    = rsp_kind ? snap_ff[rd_idx] : 8'd0;
   assign rsp_data_index   = rsp_kind ? 4'(rd_idx) : 4'd0;
   assign rsp_last         = last_word;

   // checks
   assign verdict_err = rsp_valid_ff && (verdict_ff != rfc_pkg::VERDICT_OK);
   assign mid_fire    = rsp_fire && !last_word && !load;

   `RFC_ASSERT_HOLD(a_idx_in_range, rsp_valid_ff, emit_idx_ff <= cnt_ff)
   `RFC_ASSERT_HOLD(a_err_single, verdict_err, (cnt_ff == '0) && (emit_idx_ff == '0))
   `RFC_ASSERT_NEXT(a_idx_step, mid_fire, rsp_valid_ff && (emit_idx_ff == $past(emit_step)))
   `RFC_ASSERT_HOLD(a_pos_bounded, 1'b1, pos_ff <= POS_W'(rfc_pkg::WINDOW))

endmodule

// ===== test/frame_verdict_monitor.sv =====
// watches both channels of the frame checker, predicts the result words of every
// accepted byte and compares them in order with what comes out
module frame_verdict_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_window_start,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_kind,
   input  logic [2:0] rsp_verdict,
   input  logic [7:0] rsp_frame_status,
   input  logic [3:0] rsp_data_count,
   input  logic [7:0] rsp_data_byte,
   input  logic [3:0] rsp_data_index,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   typedef struct packed {
      logic                 kind;
      rfc_pkg::verdict_type verdict;
      logic [7:0]           status;
      logic [3:0]           count;
      logic [7:0]           data;
      logic [3:0]           index;
      logic                 last;
   } frame_word_type;

   // predicted window state
   int         win_pos;
   bit         hdr_found;
   int         hdr_offset;
   logic [7:0] frame_len;
   logic [7:0] byte_sum;
   logic [7:0] status_byte;
   logic [7:0] payload [rfc_pkg::DATA_MAX];

   frame_word_type expected_words [$];
   int             mismatches;

   function automatic void clear_window();
      win_pos = 0;
      hdr_found = 0;
      hdr_offset = 0;
      frame_len = '0;
      byte_sum = '0;
      status_byte = '0;
   endfunction

   // advance the window by one byte, queue the words due at its last position
   function automatic void judge_window_byte(logic [7:0] rx, logic start);
      int                   rel;
      int                   cnt;
      rfc_pkg::verdict_type v;
      frame_word_type       w;
      if (start) clear_window();
      if (win_pos >= rfc_pkg::WINDOW) return;

      if (!hdr_found) begin
         if (win_pos + 4 < rfc_pkg::WINDOW && rx == rfc_pkg::HDR_BYTE) begin
            hdr_found = 1;
            hdr_offset = win_pos;
            byte_sum = rx;
         end
      end else begin
         rel = win_pos - hdr_offset;
         if (rel == 1) frame_len = rx;
         if (rel < int'(frame_len)) byte_sum = byte_sum + rx;
         if (rel == 2) status_byte = rx;
         if (rel >= 3 && rel - 3 < rfc_pkg::DATA_MAX) payload[rel - 3] = rx;
      end

      win_pos = win_pos + 1;
      if (win_pos != rfc_pkg::WINDOW) return;

      // verdict priority: no header, short, past window, checksum
      if (!hdr_found) v = rfc_pkg::VERDICT_NO_HEADER;
      else if (frame_len < 8'd4) v = rfc_pkg::VERDICT_SHORT;
      else if (hdr_offset + int'(frame_len) > rfc_pkg::WINDOW) v = rfc_pkg::VERDICT_PAST_WINDOW;
      else if (byte_sum != rfc_pkg::SUM_OK) v = rfc_pkg::VERDICT_BAD_SUM;
      else v = rfc_pkg::VERDICT_OK;

      w = '0;
      w.kind = KIND_VERDICT;
      w.verdict = v;
      if (v != rfc_pkg::VERDICT_OK) begin
         w.last = 1'b1;
         expected_words.push_back(w);
         return;
      end

      cnt = int'(frame_len) - 4;
      if (cnt > rfc_pkg::DATA_MAX) cnt = rfc_pkg::DATA_MAX;
      w.status = status_byte;
      w.count = 4'(cnt);
      w.last = (cnt == 0);
      expected_words.push_back(w);
      for (int i = 0; i < cnt; i++) begin
         w.kind = KIND_DATA;
         w.data = payload[i];
         w.index = 4'(i);
         w.last = (i + 1 == cnt);
         expected_words.push_back(w);
      end
   endfunction

   function automatic int field_differs(string field, int want, int got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      return 1;
   endfunction

   // byte acceptance first, then the result word of the same edge
   always @(posedge clock) begin : watch
      frame_word_type want;
      if (reset) begin
         clear_window();
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) judge_window_byte(req_rx_byte, req_window_start);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual kind %0d verdict %0d",
                        $time, rsp_kind, rsp_verdict);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               mismatches += field_differs("kind", want.kind, rsp_kind);
               mismatches += field_differs("verdict", want.verdict, rsp_verdict);
               mismatches += field_differs("frame_status", want.status, rsp_frame_status);
               mismatches += field_differs("data_count", want.count, rsp_data_count);
               mismatches += field_differs("data_byte", want.data, rsp_data_byte);
               mismatches += field_differs("data_index", want.index, rsp_data_index);
               mismatches += field_differs("last", want.last, rsp_last);
            end
         end
      end
      pending <= expected_words.size();
      fail_count <= mismatches;
   end

endmodule

// ===== test/response_frame_checker_tb.sv =====
module response_frame_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_window_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [2:0] rsp_verdict;
   logic [7:0] rsp_frame_status;
   logic [3:0] rsp_data_count;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_data_index;
   logic       rsp_last;

   int         fail_count;
   int         pending;
   int         tx_idle_pct = 13;
   int         rx_idle_pct = 67;
   logic [7:0] win_bytes [rfc_pkg::WINDOW];

   response_frame_checker dut (.*);

   frame_verdict_monitor monitor (.*);

   always #5 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // one byte word, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] rx, input logic start);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_window_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every predicted word has come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // window with a frame at off; checksum only fits for a complete frame
   task automatic build_frame(input int off, input int len, input logic [7:0] stat,
                              input bit sum_good);
      logic [7:0] acc;
      for (int p = 0; p < rfc_pkg::WINDOW; p++) begin
         win_bytes[p] = 8'($urandom_range(255));
         if (p < off && win_bytes[p] == rfc_pkg::HDR_BYTE) win_bytes[p] = 8'h5b;
      end
      if (off < rfc_pkg::WINDOW) win_bytes[off] = rfc_pkg::HDR_BYTE;
      if (off + 1 < rfc_pkg::WINDOW) win_bytes[off + 1] = 8'(len);
      if (off + 2 < rfc_pkg::WINDOW) win_bytes[off + 2] = stat;
      if (len >= 4 && off + len <= rfc_pkg::WINDOW) begin
         acc = '0;
         for (int p = off; p < off + len - 1; p++) acc = acc + win_bytes[p];
         win_bytes[off + len - 1] = rfc_pkg::SUM_OK - acc;
         if (!sum_good) win_bytes[off + len - 1] += 8'($urandom_range(1, 255));
      end
   endtask

   task automatic send_window(input int nbytes, input logic start);
      for (int p = 0; p < nbytes; p++) send_byte(win_bytes[p], (p == 0) ? start : 1'b0);
   endtask

   task automatic random_window();
      int pick;
      int off;
      pick = $urandom_range(99);
      off = $urandom_range(0, rfc_pkg::WINDOW - 5);
      if (pick < 65) begin
         build_frame(off, $urandom_range(4, rfc_pkg::WINDOW - off),
                     8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 72) begin
         build_frame(off, $urandom_range(4, rfc_pkg::WINDOW - off),
                     8'($urandom_range(255)), 0);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 77) begin
         build_frame(off, $urandom_range(0, 3), 8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 82) begin
         build_frame(off, $urandom_range(rfc_pkg::WINDOW - off + 1, 255),
                     8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 86) begin
         // header too late to count
         build_frame($urandom_range(rfc_pkg::WINDOW - 4, rfc_pkg::WINDOW - 1), 4,
                     8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 92) begin
         // window cut short by a new start
         build_frame(off, $urandom_range(4, rfc_pkg::WINDOW - off),
                     8'($urandom_range(255)), 1);
         send_window($urandom_range(1, rfc_pkg::WINDOW - 1), 1'b1);
         build_frame(off, $urandom_range(4, rfc_pkg::WINDOW - off),
                     8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
      end else if (pick < 96) begin
         // noise with stray window starts
         repeat (20) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
         build_frame(off, $urandom_range(4, rfc_pkg::WINDOW - off),
                     8'($urandom_range(255)), 1);
         send_window(rfc_pkg::WINDOW, 1'b1);
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first window after reset comes without a start mark
      build_frame(0, 8, 8'h00, 1);
      send_window(rfc_pkg::WINDOW, 1'b0);
      // longest frame, all twelve data bytes
      build_frame(0, rfc_pkg::WINDOW, 8'hff, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // empty payload at the last header position
      build_frame(rfc_pkg::WINDOW - 5, 4, 8'h80, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      build_frame(rfc_pkg::WINDOW - 5, 5, 8'h7f, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // header byte only past the last legal position
      build_frame(rfc_pkg::WINDOW - 4, 4, 8'h01, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // short length, so no checksum byte is fitted
      build_frame(3, 3, 8'ha2, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      build_frame(0, 0, 8'h00, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      build_frame(5, 1, 8'h33, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // frame runs past the window end
      build_frame(8, 10, 8'h44, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      build_frame(0, 255, 8'h55, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // bad checksum
      build_frame(2, 6, 8'h11, 0);
      send_window(rfc_pkg::WINDOW, 1'b1);
      // restart in the middle of a window, then trailing bytes after the end
      build_frame(4, 6, 8'h22, 1);
      send_window(7, 1'b1);
      build_frame(0, 5, 8'h5a, 1);
      send_window(rfc_pkg::WINDOW, 1'b1);
      send_byte(8'h5a, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      wait_for_results();

      // sender light, receiver heavy; then swapped; then no idling
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
         rx_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 13 : 0;
         repeat (4) random_window();
         wait_for_results();
      end

      repeat (32) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
